[design/kdlp_pkg.sv]
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared widths, register indexes, event codes and types of the key
// debounce block.
// ----------------------------------------------------------------------------
`default_nettype none

package kdlp_pkg;

    localparam int KEY_W = 6;
    localparam int EVT_W = 3;
    localparam int CNT_W = 16;

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET     = CNT_W'(150);
    localparam logic [CNT_W-1:0] LONG_PRESS_RESET   = CNT_W'(510);
    localparam logic [CNT_W-1:0] RELEASE_POLL_TICKS = CNT_W'(10);
    localparam logic [CNT_W-1:0] CNT_MAX            = {CNT_W{1'b1}};

    localparam int B_BIT = 5;

    // Configuration register indexes.
    localparam logic CFG_DEBOUNCE   = 1'b0;
    localparam logic CFG_LONG_PRESS = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_TIMING  = 2'd1,
        PH_RELEASE = 2'd2
    } t_b_phase;

    typedef enum logic [EVT_W-1:0] {
        EVT_UP      = 3'd0,
        EVT_DOWN    = 3'd1,
        EVT_LEFT    = 3'd2,
        EVT_RIGHT   = 3'd3,
        EVT_A       = 3'd4,
        EVT_B_SHORT = 3'd5,
        EVT_B_LONG  = 3'd6
    } t_key_event;

    // One result beat handed from the tracker to the output buffer.
    typedef struct packed {
        logic             valid;
        logic [EVT_W-1:0] evt;
    } t_result;

endpackage

`default_nettype wire

[design/kdlp_track.sv]
// ----------------------------------------------------------------------------
// kdlp_track
// Debounce counter, edge priority and key B long-press phase machine.
// Advances by one tick per accepted input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_track (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [kdlp_pkg::KEY_W-1:0]  i_key_levels,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic                        i_cfg_idx,
    input  wire logic [kdlp_pkg::CNT_W-1:0]  i_cfg_wdata,
    output kdlp_pkg::t_result                o_result
);
    import kdlp_pkg::*;

    logic [CNT_W-1:0] r_debounce;
    logic [CNT_W-1:0] r_long_press;
    logic [KEY_W-1:0] r_prev_levels;
    logic [CNT_W-1:0] r_since_accept;
    t_b_phase         r_phase;
    logic [CNT_W-1:0] r_b_timer;

    logic [CNT_W-1:0] n_since_accept;
    t_b_phase         n_phase;
    logic [CNT_W-1:0] n_b_timer;

    logic [KEY_W-1:0] falling;
    logic [CNT_W-1:0] since_inc;
    logic [CNT_W-1:0] timer_inc;
    logic             accepted;
    logic [EVT_W-1:0] key;
    logic             b_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RESET;
            r_long_press <= LONG_PRESS_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_wdata;
                CFG_LONG_PRESS: r_long_press <= i_cfg_wdata;
                default:        r_debounce   <= r_debounce;
            endcase
        end
    end

    assign falling   = r_prev_levels & ~i_key_levels;
    assign since_inc = (r_since_accept == CNT_MAX) ? r_since_accept : r_since_accept + 1'b1;
    assign timer_inc = (r_b_timer == CNT_MAX) ? r_b_timer : r_b_timer + 1'b1;
    assign accepted  = (falling != '0) && (since_inc > r_debounce);
    assign b_low     = ~i_key_levels[B_BIT];

    // Lowest set bit wins: up has the highest priority.
    always_comb begin
        key = '0;
        for (int k = KEY_W - 1; k >= 0; k--) begin
            if (falling[k]) begin
                key = EVT_W'(k);
            end
        end
    end

    always_comb begin
        n_since_accept = accepted ? '0 : since_inc;
        n_phase        = r_phase;
        n_b_timer      = r_b_timer;
        o_result.valid = 1'b0;
        o_result.evt   = EVT_UP;
        case (r_phase)
            PH_TIMING: begin
                n_b_timer = timer_inc;
                if (timer_inc >= r_long_press) begin
                    n_b_timer = '0;
                    if (b_low) begin
                        n_phase = PH_RELEASE;
                    end else begin
                        n_phase        = PH_IDLE;
                        o_result.valid = 1'b1;
                        o_result.evt   = EVT_B_SHORT;
                    end
                end
            end
            PH_RELEASE: begin
                n_b_timer = timer_inc;
                if (timer_inc >= RELEASE_POLL_TICKS) begin
                    n_b_timer = '0;
                    if (!b_low) begin
                        n_phase        = PH_IDLE;
                        o_result.valid = 1'b1;
                        o_result.evt   = EVT_B_LONG;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (accepted) begin
                    if (key == EVT_W'(B_BIT)) begin
                        n_phase   = PH_TIMING;
                        n_b_timer = '0;
                    end else begin
                        o_result.valid = 1'b1;
                        o_result.evt   = key;
                    end
                end
            end
        endcase
        o_result.valid = o_result.valid & i_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_levels  <= '1;
            r_since_accept <= '0;
            r_phase        <= PH_IDLE;
            r_b_timer      <= '0;
        end else if (i_step) begin
            r_prev_levels  <= i_key_levels;
            r_since_accept <= n_since_accept;
            r_phase        <= n_phase;
            r_b_timer      <= n_b_timer;
        end
    end

`ifndef NO_ASSERTIONS
    a_evt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.evt <= EVT_B_LONG)
        else $error("event code out of range");

    a_release_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RELEASE |-> r_b_timer < RELEASE_POLL_TICKS)
        else $error("release poll timer overran");

    a_b_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && r_phase != PH_IDLE) |=> r_phase == PH_IDLE)
        else $error("B event without return to idle");
`endif

endmodule

`default_nettype wire

[design/kdlp_outbuf.sv]
// ----------------------------------------------------------------------------
// kdlp_outbuf
// Output register with a one-entry skid stage, so that a tick can be taken
// while a finished event still waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_outbuf (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire kdlp_pkg::t_result           i_result,
    output logic                             o_full,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [kdlp_pkg::EVT_W-1:0]       o_key_event
);
    import kdlp_pkg::*;

    logic             r_out_valid;
    logic [EVT_W-1:0] r_out_evt;
    logic             r_skid_valid;
    logic [EVT_W-1:0] r_skid_evt;
    logic             out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_result.valid;
            r_skid_valid <= 1'b0;
        end else if (i_result.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_evt <= r_skid_valid ? r_skid_evt : i_result.evt;
        end else if (i_result.valid) begin
            r_skid_evt <= i_result.evt;
        end
    end

    assign o_full      = r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_key_event = r_out_evt;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_result.valid)
        else $error("result arrived while skid stage full");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved forward");
`endif

endmodule

`default_nettype wire

[design/key_debounce_long_press_core.sv]
// ----------------------------------------------------------------------------
// key_debounce_long_press_core
// Key debounce with long-press detection on key B.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick of the six active-low key lines
// and is taken whenever o_stall is low, so a tick can then be offered on
// every cycle. An accepted tick yields at most one event, registered in
// the output register; a single skid entry behind it lets one more tick be
// taken while an event waits, and o_stall rises only when both hold an
// event. Configuration writes take effect at the next tick.
`default_nettype none

module key_debounce_long_press_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [kdlp_pkg::KEY_W-1:0]  i_key_levels,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [kdlp_pkg::EVT_W-1:0]       o_key_event,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic                        i_cfg_idx,
    input  wire logic [kdlp_pkg::CNT_W-1:0]  i_cfg_wdata
);
    import kdlp_pkg::*;

    t_result result;
    logic    buf_full;
    logic    step;

    assign o_stall = buf_full;
    assign step    = i_valid && !buf_full;

    kdlp_track u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_key_levels (i_key_levels),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_result     (result)
    );

    kdlp_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .o_full      (buf_full),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_key_event (o_key_event)
    );

endmodule

`default_nettype wire
